FILE: rtl/core/b32rc_pkg.sv
// ============================================================================
// b32rc_pkg - shared types and constants of the Base32 random-case encoder
// Command format between front and back, character codes, generator
// constants and the alphabet lookup.
// ============================================================================
`default_nettype none

package b32rc_pkg;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes
    localparam int REG_INDEX_W = 2;
    localparam logic [REG_INDEX_W-1:0] REG_SEED        = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_LINE_LENGTH = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_RANDOM_CASE = 2'd2;

    // Configuration reset values
    localparam logic [7:0] LINE_LENGTH_RESET = 8'd72;
    localparam logic       RANDOM_CASE_RESET = 1'b1;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Output characters
    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] CHAR_PAD    = 8'd61;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [4:0] LETTER_COUNT = 5'd26;

    // Generator reset state and shift / rotate amounts
    localparam logic [31:0] PRNG_RESET0 = 32'd123456789;
    localparam logic [31:0] PRNG_RESET1 = 32'd362436069;
    localparam logic [31:0] PRNG_RESET2 = 32'd521288629;
    localparam logic [31:0] PRNG_RESET3 = 32'd88675123;
    localparam int XS_SHL_T = 11;
    localparam int XS_SHR_W = 19;
    localparam int XS_SHR_T = 8;
    localparam int SEED_ROT1 = 17;
    localparam int SEED_ROT2 = 31;
    localparam int SEED_ROT3 = 18;

    // One classified item: up to two symbols, then padding signs
    typedef struct packed {
        logic       is_end;
        logic [1:0] nsym;
        logic [4:0] idx0;
        logic [4:0] idx1;
        logic [2:0] npad;
    } cmd_t;

    // Configuration write request
    typedef struct packed {
        logic                   en;
        logic [REG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } cfg_wr_t;

    // Map a 5-bit group to A-Z then 2-7
    function automatic logic [7:0] alpha_char(input logic [4:0] idx);
        logic [7:0] ch;
        if (idx < LETTER_COUNT)
            ch = 8'd65 + {3'b000, idx};
        else
            ch = 8'd50 + {3'b000, idx - LETTER_COUNT};
        return ch;
    endfunction

    // Rotate a word right by a fixed amount
    function automatic logic [31:0] rotr32(input logic [31:0] v, input int r);
        return (v >> r) | (v << (32 - r));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b32rc_if.sv
// ============================================================================
// b32rc_if - channel interfaces of the Base32 random-case encoder
// Input item, result item and configuration write channels, each with
// valid / ready and its payload.
// ============================================================================
`default_nettype none

interface b32rc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface b32rc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface b32rc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/base32_encoder_random_case_top.sv
// ============================================================================
// base32_encoder_random_case_top - Base32 text encoder with random case
// Front classifier, command queue and character sequencer.
// ============================================================================
// The block puts out one character per cycle while the sink takes it. A data
// byte yields one or two symbols, and each may be followed by a newline at a
// line end. An end item yields at most a flush symbol and six padding signs,
// each followed by a newline when the line length is one. An end item with
// nothing to flush, pad or close still passes through the back part, which
// puts out no character for it. The character sequencer in the back part and
// its output register produce the characters. The front accepts an item every
// cycle while the command queue (QUEUE_DEPTH entries) has room, and when the
// back part is idle an accepted item passes the queue, the back part's command
// registers and its output register before its first character appears.
// Configuration writes are taken every cycle and must be issued only while
// no item is in flight.
`default_nettype none

module base32_encoder_random_case_top #(
    parameter int QUEUE_DEPTH = b32rc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    b32rc_in_if.sink     in_ch,
    b32rc_out_if.source  out_ch,
    b32rc_cfg_if.sink    cfg
);
    import b32rc_pkg::*;

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    cfg_wr_t cfg_wr;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;

    // Configuration requests are always taken
    assign cfg.ready    = 1'b1;
    assign cfg_wr.en    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    b32rc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    b32rc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    b32rc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cmd_valid (q_valid),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_ch    (out_ch)
    );

`ifndef SYNTHESIS
    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // A request taken from a full queue frees a slot for the next cycle
    a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && q_pop && !q_push) |=> !q_full)
        else $error("queue stays full after pop");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/b32rc_front.sv
// ============================================================================
// b32rc_front - input side of the Base32 random-case encoder
// Accepts bytes and end items, keeps the bit buffer and byte phase, and
// turns each item into a command of symbol indexes and padding count.
// ============================================================================
`default_nettype none

module b32rc_front (
    input  logic              clk,
    input  logic              rst_n,
    b32rc_in_if.sink          in_ch,
    input  logic              q_full,
    output logic              q_push,
    output b32rc_pkg::cmd_t   q_cmd
);
    import b32rc_pkg::*;

    logic [11:0] bit_buffer_reg, bit_buffer_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [2:0]  byte_phase_reg, byte_phase_next;

    logic [3:0]  cnt;
    logic [11:0] buf_new;
    logic [3:0]  sh0, sh1;
    logic [11:0] shifted0, shifted1;
    logic [4:0]  flush_mask;
    logic [4:0]  flush_idx;
    logic        two_sym;
    logic        flush;

    // Accept whenever the queue has room
    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    // Split the new byte into symbol groups
    always_comb
    begin
        cnt      = {1'b0, bit_count_reg[2:0]} + 4'd8;
        buf_new  = {bit_buffer_reg[3:0], in_ch.data_byte};
        two_sym  = (cnt >= 4'd10);
        sh0      = cnt - 4'd5;
        sh1      = cnt - 4'd10;
        shifted0 = buf_new >> sh0;
        shifted1 = buf_new >> sh1;
        flush      = (bit_count_reg != 4'd0) && (bit_count_reg < 4'd5);
        flush_mask = (5'd1 << bit_count_reg[2:0]) - 5'd1;
        flush_idx  = ({1'b0, bit_buffer_reg[3:0]} & flush_mask)
                     << (3'd5 - bit_count_reg[2:0]);
    end

    // Build the command and the next buffer state
    always_comb
    begin
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        byte_phase_next = byte_phase_reg;
        q_cmd           = '0;
        if (in_ch.kind == KIND_DATA)
        begin
            q_cmd.is_end    = 1'b0;
            q_cmd.nsym      = two_sym ? 2'd2 : 2'd1;
            q_cmd.idx0      = shifted0[4:0];
            q_cmd.idx1      = shifted1[4:0];
            q_cmd.npad      = 3'd0;
            bit_buffer_next = buf_new;
            bit_count_next  = two_sym ? sh1 : sh0;
            byte_phase_next = (byte_phase_reg >= 3'd4) ? 3'd0 : byte_phase_reg + 3'd1;
        end
        else
        begin
            q_cmd.is_end = 1'b1;
            q_cmd.nsym   = flush ? 2'd1 : 2'd0;
            q_cmd.idx0   = flush_idx;
            q_cmd.idx1   = 5'd0;
            case (byte_phase_reg)
                3'd1:    q_cmd.npad = 3'd6;
                3'd2:    q_cmd.npad = 3'd4;
                3'd3:    q_cmd.npad = 3'd3;
                3'd4:    q_cmd.npad = 3'd1;
                default: q_cmd.npad = 3'd0;
            endcase
            bit_buffer_next = '0;
            bit_count_next  = '0;
            byte_phase_next = '0;
        end
    end

    // Hold message state, advance on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            byte_phase_reg <= '0;
        end
        else if (q_push)
        begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
            byte_phase_reg <= byte_phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/b32rc_queue.sv
// ============================================================================
// b32rc_queue - command queue between front and back
// Small register FIFO of classified commands; each side stalls on its own.
// ============================================================================
`default_nettype none

module b32rc_queue #(
    parameter int DEPTH = b32rc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b32rc_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output b32rc_pkg::cmd_t head
);
    import b32rc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Step a pointer with wrap at the depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: rtl/core/b32rc_back.sv
// ============================================================================
// b32rc_back - output side of the Base32 random-case encoder
// Runs one command at a time, one character per cycle while the output slot
// is free: symbols with random case, padding, line breaks and the closing
// newline. Owns the generator, column count and configuration registers.
// ============================================================================
`default_nettype none

module b32rc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  b32rc_pkg::cfg_wr_t cfg_wr,
    input  logic              cmd_valid,
    input  b32rc_pkg::cmd_t   cmd,
    output logic              cmd_pop,
    b32rc_out_if.source       out_ch
);
    import b32rc_pkg::*;

    // Command progress
    logic        busy_reg, busy_next;
    logic        is_end_reg, is_end_next;
    logic [1:0]  sym_left_reg, sym_left_next;
    logic [4:0]  idx0_reg, idx0_next;
    logic [4:0]  idx1_reg, idx1_next;
    logic [2:0]  pad_left_reg, pad_left_next;
    logic        nl_pend_reg, nl_pend_next;
    logic        nl_last_reg, nl_last_next;
    logic [7:0]  column_reg, column_next;

    // Generator and configuration
    logic [31:0] prng_reg [4];
    logic [31:0] prng_next [4];
    logic [7:0]  line_length_reg, line_length_next;
    logic        random_case_reg, random_case_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  symbol_reg, symbol_next;
    logic        last_reg, last_next;

    logic        slot_free;
    logic        emit;
    logic        done;
    logic [7:0]  ch;
    logic        ch_last;
    logic        final_char;
    logic [7:0]  col_after;
    logic [31:0] xs_t;
    logic [31:0] xs_w;

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.symbol = symbol_reg;
    assign out_ch.last   = last_reg;
    assign slot_free     = !out_valid_reg || out_ch.ready;
    assign col_after     = column_reg + 8'd1;

    // Next generator word
    always_comb
    begin
        xs_t = prng_reg[0] ^ (prng_reg[0] << XS_SHL_T);
        xs_w = prng_reg[3] ^ (prng_reg[3] >> XS_SHR_W) ^ xs_t ^ (xs_t >> XS_SHR_T);
    end

    // Sequence one character per cycle while the output slot is free
    always_comb
    begin
        busy_next        = busy_reg;
        is_end_next      = is_end_reg;
        sym_left_next    = sym_left_reg;
        idx0_next        = idx0_reg;
        idx1_next        = idx1_reg;
        pad_left_next    = pad_left_reg;
        nl_pend_next     = nl_pend_reg;
        nl_last_next     = nl_last_reg;
        column_next      = column_reg;
        line_length_next = line_length_reg;
        random_case_next = random_case_reg;
        for (int i = 0; i < 4; i++)
            prng_next[i] = prng_reg[i];
        emit       = 1'b0;
        done       = 1'b0;
        ch         = CHAR_NL;
        ch_last    = 1'b0;
        final_char = 1'b0;

        if (busy_reg && slot_free)
        begin
            if (nl_pend_reg)
            begin
                // Line break after a counted character
                emit         = 1'b1;
                ch           = CHAR_NL;
                ch_last      = nl_last_reg;
                nl_pend_next = 1'b0;
                done         = nl_last_reg;
            end
            else if (sym_left_reg != 2'd0 || pad_left_reg != 3'd0)
            begin
                emit = 1'b1;
                if (sym_left_reg != 2'd0)
                begin
                    // Symbol: advance generator, maybe lower the letter
                    ch = alpha_char(idx0_reg);
                    if (idx0_reg < LETTER_COUNT && xs_w[0] && random_case_reg)
                        ch = ch + CASE_OFFSET;
                    prng_next[0]  = prng_reg[1];
                    prng_next[1]  = prng_reg[2];
                    prng_next[2]  = prng_reg[3];
                    prng_next[3]  = xs_w;
                    sym_left_next = sym_left_reg - 2'd1;
                    idx0_next     = idx1_reg;
                    final_char    = (sym_left_reg == 2'd1) && (pad_left_reg == 3'd0);
                end
                else
                begin
                    ch            = CHAR_PAD;
                    pad_left_next = pad_left_reg - 3'd1;
                    final_char    = (pad_left_reg == 3'd1);
                end
                // Count the character, break the line when full
                if (col_after >= line_length_reg)
                begin
                    column_next  = 8'd0;
                    nl_pend_next = 1'b1;
                    nl_last_next = final_char;
                end
                else
                begin
                    column_next = col_after;
                    if (final_char && !(is_end_reg && col_after != 8'd0))
                    begin
                        ch_last = 1'b1;
                        done    = 1'b1;
                    end
                end
            end
            else
            begin
                // End of message: close a partial line
                if (column_reg != 8'd0)
                begin
                    emit    = 1'b1;
                    ch      = CHAR_NL;
                    ch_last = 1'b1;
                end
                column_next = 8'd0;
                done        = 1'b1;
            end
        end

        // Load the next command as the current one finishes
        cmd_pop = cmd_valid && (!busy_reg || done);
        if (cmd_pop)
        begin
            busy_next     = 1'b1;
            is_end_next   = cmd.is_end;
            sym_left_next = cmd.nsym;
            idx0_next     = cmd.idx0;
            idx1_next     = cmd.idx1;
            pad_left_next = cmd.npad;
            nl_pend_next  = 1'b0;
            nl_last_next  = 1'b0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end

        // Configuration writes, to be issued only while idle; the block does not enforce it
        if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                REG_SEED:
                begin
                    prng_next[0] = prng_reg[0] ^ cfg_wr.data;
                    prng_next[1] = prng_reg[1] ^ rotr32(cfg_wr.data, SEED_ROT1);
                    prng_next[2] = prng_reg[2] ^ rotr32(cfg_wr.data, SEED_ROT2);
                    prng_next[3] = prng_reg[3] ^ rotr32(cfg_wr.data, SEED_ROT3);
                end
                REG_LINE_LENGTH: line_length_next = cfg_wr.data[7:0];
                REG_RANDOM_CASE: random_case_next = cfg_wr.data[0];
                default: ;
            endcase
        end

        // Output register: load on emit, drop when taken
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            symbol_next    = ch;
            last_next      = ch_last;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control, generator and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            is_end_reg      <= 1'b0;
            sym_left_reg    <= '0;
            pad_left_reg    <= '0;
            nl_pend_reg     <= 1'b0;
            nl_last_reg     <= 1'b0;
            column_reg      <= '0;
            prng_reg[0]     <= PRNG_RESET0;
            prng_reg[1]     <= PRNG_RESET1;
            prng_reg[2]     <= PRNG_RESET2;
            prng_reg[3]     <= PRNG_RESET3;
            line_length_reg <= LINE_LENGTH_RESET;
            random_case_reg <= RANDOM_CASE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            is_end_reg      <= is_end_next;
            sym_left_reg    <= sym_left_next;
            pad_left_reg    <= pad_left_next;
            nl_pend_reg     <= nl_pend_next;
            nl_last_reg     <= nl_last_next;
            column_reg      <= column_next;
            for (int i = 0; i < 4; i++)
                prng_reg[i] <= prng_next[i];
            line_length_reg <= line_length_next;
            random_case_reg <= random_case_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx0_reg   <= idx0_next;
        idx1_reg   <= idx1_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_base32_encoder_random_case_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_base32_encoder_random_case_top - Base32 random-case encoder testbench
// Sends byte and end-of-message requests into the encoder, predicts every
// output character (symbol, padding, newline, case from the xorshift
// generator) with an in-bench model and compares each character that is
// taken from the output. Random idling on both sides, one long output stall.
// ============================================================================
`default_nettype none

module tb_base32_encoder_random_case_top;

    import b32rc_pkg::*;

    // Register index that maps to no register
    localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } text_char_t;

    logic clk;
    logic rst_n;

    b32rc_in_if  in_ch ();
    b32rc_out_if out_ch ();
    b32rc_cfg_if cfg_ch ();

    base32_encoder_random_case_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // Encoder model state and settings
    logic [11:0] pend_buf;
    logic [3:0]  pend_cnt;
    logic [2:0]  byte_mod;
    logic [7:0]  line_col;
    logic [31:0] gen [4];
    logic [7:0]  chars_per_line;
    logic        lower_en;

    text_char_t item_chars[$];
    text_char_t expected_chars[$];
    text_char_t want;

    int mismatch_count = 0;
    int items_sent = 0;
    int stall_left = 0;
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;
    bit hold_req = 1'b0;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        pend_buf       = '0;
        pend_cnt       = '0;
        byte_mod       = '0;
        line_col       = '0;
        gen[0]         = 32'd123456789;
        gen[1]         = 32'd362436069;
        gen[2]         = 32'd521288629;
        gen[3]         = 32'd88675123;
        chars_per_line = 8'd72;
        lower_en       = 1'b1;
    endfunction

    function automatic logic [31:0] gen_next();
        logic [31:0] t;
        logic [31:0] w;
        t      = gen[0] ^ (gen[0] << XS_SHL_T);
        w      = gen[3];
        gen[0] = gen[1];
        gen[1] = gen[2];
        gen[2] = w;
        w      = (w ^ (w >> XS_SHR_W)) ^ (t ^ (t >> XS_SHR_T));
        gen[3] = w;
        return w;
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        text_char_t c;
        c.symbol = ch;
        c.last   = 1'b0;
        item_chars.push_back(c);
    endfunction

    // Count a character on the line and break the line when it is full
    function automatic void put_counted(input logic [7:0] ch);
        put_char(ch);
        line_col = line_col + 8'd1;
        if (line_col >= chars_per_line) begin
            put_char(CHAR_NL);
            line_col = '0;
        end
    endfunction

    // Map a 5-bit group, advance the generator and maybe lower a letter
    function automatic void put_group(input logic [4:0] grp);
        logic [7:0]  ch;
        logic [31:0] r;
        if (grp < LETTER_COUNT)
            ch = 8'h41 + {3'b000, grp};
        else
            ch = 8'h32 + {3'b000, 5'(grp - LETTER_COUNT)};
        r = gen_next();
        if (grp < LETTER_COUNT && r[0] && lower_en)
            ch = ch + CASE_OFFSET;
        put_counted(ch);
    endfunction

    function automatic void encode_item(input logic kind, input logic [7:0] din);
        logic [11:0] low;
        int          pads;
        item_chars.delete();
        if (kind == KIND_DATA) begin
            pend_buf = {pend_buf[3:0], din};
            pend_cnt = {1'b0, pend_cnt[2:0]} + 4'd8;
            byte_mod = (byte_mod >= 3'd4) ? 3'd0 : byte_mod + 3'd1;
            while (pend_cnt >= 4'd5) begin
                pend_cnt = pend_cnt - 4'd5;
                put_group(5'(pend_buf >> pend_cnt));
            end
        end else begin
            // flush leftover bits, zero-padded on the right
            if (pend_cnt != 0 && pend_cnt < 4'd5) begin
                low = pend_buf & ((12'd1 << pend_cnt) - 12'd1);
                put_group(5'(low << (5 - pend_cnt)));
            end
            case (byte_mod)
                3'd1:    pads = 6;
                3'd2:    pads = 4;
                3'd3:    pads = 3;
                3'd4:    pads = 1;
                default: pads = 0;
            endcase
            repeat (pads) put_counted(CHAR_PAD);
            if (line_col != 0)
                put_char(CHAR_NL);
            pend_buf = '0;
            pend_cnt = '0;
            byte_mod = '0;
            line_col = '0;
        end
        if (item_chars.size() > 0)
            item_chars[item_chars.size() - 1].last = 1'b1;
        foreach (item_chars[i])
            expected_chars.push_back(item_chars[i]);
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_SEED: begin
                gen[0] = gen[0] ^ val;
                gen[1] = gen[1] ^ {val[16:0], val[31:17]};
                gen[2] = gen[2] ^ {val[30:0], val[31]};
                gen[3] = gen[3] ^ {val[17:0], val[31:18]};
            end
            REG_LINE_LENGTH: chars_per_line = val[7:0];
            REG_RANDOM_CASE: lower_en = val[0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [7:0] din);
        int gap;
        // hold the request off for a random burst now and then
        if (src_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= din;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        encode_item(kind, din);
        items_sent++;
    endtask

    task automatic send_message(input int n_bytes);
        repeat (n_bytes) send_item(KIND_DATA, 8'($urandom));
        send_item(KIND_END, 8'($urandom));
    endtask

    // Drop the request and wait until every character has come out
    task automatic drain_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, long hold on request
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 250;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (snk_idle && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each taken character with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, actual %h last %b",
                         $time, out_ch.symbol, out_ch.last);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (out_ch.symbol !== want.symbol) begin
                    $display("%0t: symbol mismatch, expected %h, actual %h",
                             $time, want.symbol, out_ch.symbol);
                    mismatch_count++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want.last, out_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_message();
        send_item(KIND_END, 8'hFF);
        drain_idle();
    endtask

    // Every byte count mod 5, with extreme byte values
    task automatic test_message_lengths();
        logic [7:0] pattern [15];
        int         k;
        pattern = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE,
                    8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'h5A};
        k = 0;
        for (int len = 1; len <= 5; len++) begin
            for (int i = 0; i < len; i++) begin
                send_item(KIND_DATA, pattern[k]);
                k++;
            end
            send_item(KIND_END, 8'h00);
        end
        drain_idle();
    endtask

    // Line length zero, and shortening the line in mid-line
    task automatic test_line_breaks();
        write_reg(REG_LINE_LENGTH, 32'd0);
        send_item(KIND_DATA, 8'hC7);
        send_item(KIND_END, 8'h12);
        drain_idle();
        write_reg(REG_LINE_LENGTH, 32'd255);
        write_reg(REG_LINE_LENGTH, 32'd6);
        send_item(KIND_DATA, 8'h3B);
        send_item(KIND_DATA, 8'hE4);
        drain_idle();
        write_reg(REG_LINE_LENGTH, 32'd1);
        send_item(KIND_DATA, 8'h91);
        send_item(KIND_END, 8'h00);
        drain_idle();
        write_reg(REG_LINE_LENGTH, 32'(LINE_LENGTH_RESET));
    endtask

    // Seed extremes, case off, and a write to an unused index
    task automatic test_seed_and_case();
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_RANDOM_CASE, 32'd0);
        send_item(KIND_DATA, 8'h4D);
        send_item(KIND_END, 8'hA5);
        drain_idle();
        write_reg(REG_RANDOM_CASE, 32'd1);
        write_reg(REG_SEED, 32'd0);
    endtask

    // Stall the output for a long stretch while requests keep coming
    task automatic test_backpressure();
        src_idle = 1'b0;
        @(negedge clk);
        hold_req = 1'b1;
        send_message(24);
        drain_idle();
        src_idle = 1'b1;
    endtask

    // Random messages under several settings; the last phase runs flat out
    task automatic test_random_messages();
        int          budget;
        int          len;
        logic [31:0] ll;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       ll = 32'd1;
                1:       ll = 32'd255;
                2:       ll = $urandom_range(2, 12);
                default: ll = $urandom_range(1, 80);
            endcase
            write_reg(REG_SEED, $urandom);
            write_reg(REG_LINE_LENGTH, ll);
            write_reg(REG_RANDOM_CASE, 32'(phase % 2 == 0));
            if (phase == 5) begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end
            budget = items_sent + 30;
            while (items_sent < budget) begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(13, 30);
                else
                    len = $urandom_range(0, 12);
                send_message(len);
            end
            drain_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_DATA;
        in_ch.data_byte = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_SEED;
        cfg_ch.data     = 32'd0;
        reset_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_message_lengths();
        test_line_breaks();
        test_seed_and_case();
        test_backpressure();
        test_random_messages();

        drain_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_base32_encoder_random_case_top passed");
        else
            $display("tb_base32_encoder_random_case_top failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_base32_encoder_random_case_top failed");
        $finish;
    end

endmodule

`default_nettype wire
